// ----- sv/dwr_pkg.sv -----
// Shared constants for the draw-without-replacement block.
package dwr_pkg;

    localparam int NUMBER_COUNT_DEF  = 128;  // default size of the number pool
    localparam int HISTORY_DEPTH_DEF = 5;    // default recent-history depth
    localparam int RND_W             = 31;   // random word width
    localparam int NUM_W             = 8;    // width of number and count outputs
    localparam int HVAL_W            = 3;    // width of the history valid count
    localparam int OUT_SLOTS         = 5;    // history slots shown on the ports

endpackage

// ----- sv/draw_without_replacement_top.sv -----
// Random draw without replacement from 1..NUMBER_COUNT, with recent history.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  request  | i_random_value                          | start && !busy
//  result   | o_exhausted, o_drawn_number,            | o_done, one cycle, no stall
//           | o_remaining_count, o_history_*          |
//
// A draw runs a bit-serial restoring modulo of the random value by the remaining count
// on the shared subtract/compare unit, then scans the drawn map one entry per cycle up
// to and including the selected number; busy stays high until the result, so a new
// draw is not taken before the last one is through.
// An exhausted draw gives its result in the cycle after acceptance, busy stays low.
// Synchronous active-low reset clears the history and sets the remaining count to
// NUMBER_COUNT; busy then stays high while a clearing pass zeroes the drawn map.
// The receiver cannot stall: each result is shown for exactly the o_done cycle.
module draw_without_replacement_top
    import dwr_pkg::*;
#(
    parameter int NUMBER_COUNT  = NUMBER_COUNT_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [RND_W-1:0]  i_random_value,
    output logic              busy,
    output logic              o_done,
    output logic              o_exhausted,
    output logic [NUM_W-1:0]  o_drawn_number,
    output logic [NUM_W-1:0]  o_remaining_count,
    output logic [HVAL_W-1:0] o_history_valid,
    output logic [NUM_W-1:0]  o_history_oldest,
    output logic [NUM_W-1:0]  o_history_second,
    output logic [NUM_W-1:0]  o_history_third,
    output logic [NUM_W-1:0]  o_history_fourth,
    output logic [NUM_W-1:0]  o_history_newest
);

    localparam int CW  = $clog2(NUMBER_COUNT + 1);   // counts 0..NUMBER_COUNT
    localparam int IW  = $clog2(NUMBER_COUNT);       // map index
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);  // history fill count
    localparam int DCW = $clog2(RND_W);              // modulo bit counter

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_SCAN
    } t_state;

    t_state                  r_state;
    logic                    r_map [NUMBER_COUNT];
    logic                    r_rd;
    logic [IW-1:0]           r_rd_idx;
    logic [CW-1:0]           r_left;
    logic [RND_W-1:0]        r_rnd;
    logic [CW-1:0]           r_rem;
    logic [DCW-1:0]          r_dcnt;
    logic [IW-1:0]           r_idx;
    logic [CW-1:0]           r_seen;
    logic [NUM_W-1:0]        r_hist [HISTORY_DEPTH];
    logic [HCW-1:0]          r_hcnt;
    logic                    r_done;
    logic                    r_exh;
    logic [CW-1:0]           r_num;
    logic [CW-1:0]           r_left_out;

    logic [CW:0]             n_rem_sh;
    logic                    n_rem_ge;
    logic [CW-1:0]           n_number;
    logic                    w_pick;
    logic                    w_we;
    logic [IW-1:0]           w_waddr;
    logic                    w_wdata;
    logic [NUM_W-1:0]        w_slot [OUT_SLOTS];

    // shared unit: one restoring-division step
    assign n_rem_sh = {r_rem, r_rnd[RND_W-1]};
    assign n_rem_ge = (n_rem_sh >= {1'b0, r_left});
    assign n_number = CW'(r_rd_idx) + CW'(1);

    // map port: clearing pass after reset, or marking the selected number
    assign w_pick  = (r_state == S_SCAN) && !r_rd && (r_seen == r_rem);
    assign w_we    = (r_state == S_CLEAR) || w_pick;
    assign w_waddr = (r_state == S_CLEAR) ? r_idx : r_rd_idx;
    assign w_wdata = (r_state != S_CLEAR);

    // drawn map, registered read at r_idx; r_rd_idx tags the entry in r_rd
    always_ff @(posedge i_clk) begin
        if (w_we)
            r_map[w_waddr] <= w_wdata;
        r_rd     <= r_map[r_idx];
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_left  <= CW'(NUMBER_COUNT);
            r_hcnt  <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) r_hist[i] <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == IW'(NUMBER_COUNT - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        if (r_left == '0) begin
                            r_exh      <= 1'b1;
                            r_num      <= '0;
                            r_left_out <= '0;
                            r_done     <= 1'b1;
                        end else begin
                            r_rnd   <= i_random_value;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_idx   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem_ge ? CW'(n_rem_sh - {1'b0, r_left}) : CW'(n_rem_sh);
                    r_rnd  <= r_rnd << 1;
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(RND_W - 1)) begin
                        // entry 0 is already in r_rd, fetch entry 1 next
                        r_idx   <= IW'(1);
                        r_seen  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + IW'(1);
                    if (!r_rd) begin
                        if (r_seen == r_rem) begin
                            r_left       <= r_left - CW'(1);
                            r_left_out   <= r_left - CW'(1);
                            r_num        <= n_number;
                            r_exh        <= 1'b0;
                            r_done       <= 1'b1;
                            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                                r_hist[i] <= r_hist[i+1];
                            r_hist[HISTORY_DEPTH-1] <= NUM_W'(n_number);
                            if (r_hcnt != HCW'(HISTORY_DEPTH))
                                r_hcnt <= r_hcnt + HCW'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_seen <= r_seen + CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // port slots beyond the history depth read zero
    for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_slot
        if (j < HISTORY_DEPTH) begin : g_used
            assign w_slot[j] = r_hist[j];
        end else begin : g_empty
            assign w_slot[j] = '0;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_exhausted       = r_exh;
    assign o_drawn_number    = NUM_W'(r_num);
    assign o_remaining_count = NUM_W'(r_left_out);
    assign o_history_valid   = HVAL_W'(r_hcnt);
    assign o_history_oldest  = w_slot[0];
    assign o_history_second  = w_slot[1];
    assign o_history_third   = w_slot[2];
    assign o_history_fourth  = w_slot[3];
    assign o_history_newest  = w_slot[4];

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CW'(NUMBER_COUNT))
        else $error("remaining count above pool size");

    a_exh_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && r_left == '0) |=> (o_done && o_exhausted))
        else $error("exhausted draw not reported next cycle");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_seen <= r_rem && r_rem < r_left))
        else $error("scan passed the selected index");

    a_drawn_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_exhausted) |-> (r_num != '0 && !busy))
        else $error("successful draw with number zero");

    a_hist_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HCW'(HISTORY_DEPTH))
        else $error("history count above depth");

endmodule
